/* rtl/bitmap_block_allocator_macros.svh */
// Assertion macros used by the top level of the bitmap block allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap block allocator: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap block allocator: next-cycle check failed");
`else
`define BBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/bba_pkg.sv */
// Shared constants, codes and control/status types of the bitmap block allocator.
`timescale 1ns / 1ps
package bba_pkg;

	localparam int DEF_BLOCK_COUNT = 4096;
	localparam int DEF_WORD_BITS   = 32;

	localparam int CMD_W   = 2;
	localparam int BID_W   = 12;
	localparam int ST_W    = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FORMAT  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

	localparam logic [BID_W-1:0] FIRST_ALLOC_RST   = 12'd514;
	localparam logic [BID_W-1:0] RESERVED_LAST_RST = 12'd513;

	// Register select is address bit 2 (registers at byte offsets 0 and 4).
	localparam int   REG_SEL_BIT       = 2;
	localparam logic REG_FIRST_ALLOC   = 1'b0;
	localparam logic REG_RESERVED_LAST = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic div;
		logic read;
		logic look;
		logic scan;
		logic sweep;
		logic sweep_zero;
		logic resp_load;
	} dp_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             start_ok;
		logic             scan_found;
		logic             scan_full;
		logic             sweep_last;
	} dp_stat_t;

endpackage

/* rtl/bba_req_if.sv */
// Request channel of the bitmap block allocator: command and block id.
`timescale 1ns / 1ps
interface bba_req_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [BID_W-1:0] blk_num;

	modport source (output valid, output command, output blk_num, input ready);
	modport sink (input valid, input command, input blk_num, output ready);
endinterface

/* rtl/bba_rsp_if.sv */
// Response channel of the bitmap block allocator: block, status and used flag.
`timescale 1ns / 1ps
interface bba_rsp_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BID_W-1:0] result_block;
	logic [ST_W-1:0]  status;
	logic             is_used;

	modport source (output valid, output result_block, output status, output is_used,
		input ready);
	modport sink (input valid, input result_block, input status, input is_used,
		output ready);
endinterface

/* rtl/bba_ctrl.sv */
// Controller state machine of the bitmap block allocator.
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_LOOK  = 3'd4;
	localparam logic [2:0] S_SCAN  = 3'd5;
	localparam logic [2:0] S_FMT   = 3'd6;
	localparam logic [2:0] S_RESP  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				ctl.sweep      = 1'b1;
				ctl.sweep_zero = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.take = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				ctl.div = 1'b1;
				if (stat.cmd == CMD_ALLOC && !stat.start_ok) begin
					state_d = S_RESP;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				ctl.read = 1'b1;
				state_d  = (stat.cmd == CMD_ALLOC) ? S_SCAN : S_LOOK;
			end
			S_LOOK: begin
				ctl.look = 1'b1;
				state_d  = (stat.cmd == CMD_FORMAT) ? S_FMT : S_RESP;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_found || stat.scan_full) begin
					state_d = S_RESP;
				end
			end
			S_FMT: begin
				ctl.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_valid_q || rsp_ready) begin
					ctl.resp_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

/* rtl/bba_dp.sv */
// Datapath of the bitmap block allocator: used-map memory, word scan and sweep.
`timescale 1ns / 1ps
module bba_dp import bba_pkg::*; #(
	parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
	parameter int WORD_BITS   = DEF_WORD_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_ctl_t          ctl,
	output dp_stat_t         stat,
	input  logic [CMD_W-1:0] command,
	input  logic [BID_W-1:0] blk_num,
	input  logic [BID_W-1:0] first_alloc_block,
	input  logic [BID_W-1:0] reserved_last,
	output logic [BID_W-1:0] result_block,
	output logic [ST_W-1:0]  status,
	output logic             is_used
);

	localparam int MAP_WORDS = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int BN_W      = $clog2(BLOCK_COUNT);
	localparam int BASE_W    = BN_W + 1;
	localparam int CMP_W     = ((BASE_W > BID_W) ? BASE_W : BID_W) + 1;
	localparam int TAIL      = BLOCK_COUNT - (MAP_WORDS - 1) * WORD_BITS;
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
	localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] LAST_MASK = ONES >> (WORD_BITS - TAIL);
	// Division by the word size as a multiply by a rounded-up reciprocal,
	// exact for every 12-bit dividend.
	localparam int DIV_SH = BID_W + BIT_W;
	localparam int RCP_W  = BID_W + 2;
	localparam int PROD_W = BID_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);

	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [BID_W-1:0]  id_q;
	logic [BID_W-1:0]  opnd_q;
	logic [BID_W-1:0]  q_q;
	logic              in_range_q;
	logic [BIT_W-1:0]  r_q;
	logic [AW-1:0]     ev_addr_s1;
	logic [BASE_W-1:0] ev_base_s1;
	logic              ev_first_s1;
	logic [AW-1:0]     rd_ptr_q;
	logic [BASE_W-1:0] base_q;
	logic              rd_done_q;
	logic [AW-1:0]     sw_ptr_q;
	logic [BASE_W-1:0] sw_base_q;
	logic [BID_W-1:0]  res_block_q;
	logic [ST_W-1:0]   res_status_q;
	logic              res_used_q;
	logic [BID_W-1:0]  out_block_q;
	logic [ST_W-1:0]   out_status_q;
	logic              out_used_q;

	logic [BID_W-1:0]     start_blk;
	logic                 start_ok;
	logic                 id_in_range;
	logic [BID_W-1:0]     div_opnd;
	logic [PROD_W-1:0]    div_prod;
	logic [BID_W-1:0]     div_quo;
	logic [BID_W-1:0]     q_base;
	logic [AW-1:0]        q_addr;
	logic [BIT_W-1:0]     rem;
	logic                 ev_last;
	logic [WORD_BITS-1:0] low_mask;
	logic [WORD_BITS-1:0] free;
	logic [BIT_W-1:0]     free_idx;
	logic                 found;
	logic [BID_W-1:0]     alloc_blk;
	logic [WORD_BITS-1:0] bit_sel;
	logic [WORD_BITS-1:0] free_sel;
	logic                 id_bit;
	logic                 release_ok;
	logic [CMP_W-1:0]     fmt_diff;
	logic [WORD_BITS-1:0] fmt_mask;
	logic                 sweep_last;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;

	// Operand split into word index and bit offset.
	assign start_blk   = (first_alloc_block == '0) ? BID_W'(1) : first_alloc_block;
	assign start_ok    = 32'(start_blk) < 32'(BLOCK_COUNT);
	assign id_in_range = 32'(id_q) < 32'(BLOCK_COUNT);
	assign div_opnd    = (cmd_q == CMD_ALLOC) ? start_blk : id_q;
	assign div_prod    = PROD_W'(div_opnd) * PROD_W'(RECIP);
	assign div_quo     = BID_W'(div_prod >> DIV_SH);
	assign q_base      = q_q * BID_W'(WORD_BITS);
	assign q_addr      = AW'(q_q);
	assign rem         = BIT_W'(opnd_q - q_base);

	// Search of the word that came back from the memory.
	assign ev_last  = (ev_addr_s1 == LAST_WORD);
	assign low_mask = ev_first_s1 ? (ONES << r_q) : ONES;
	assign free     = ~rdata_q & low_mask & (ev_last ? LAST_MASK : ONES);
	assign found    = |free;

	always_comb begin
		free_idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free[b]) begin
				free_idx = BIT_W'(b);
			end
		end
	end

	assign alloc_blk = BID_W'(ev_base_s1 + BASE_W'(free_idx));
	assign free_sel  = WORD_BITS'(1) << free_idx;
	assign bit_sel   = WORD_BITS'(1) << r_q;
	assign id_bit    = in_range_q & rdata_q[r_q];
	assign release_ok = (id_q != '0) && id_bit;

	// Format fill pattern for the word at the sweep pointer.
	assign fmt_diff = CMP_W'(reserved_last) - CMP_W'(sw_base_q);
	always_comb begin
		if (fmt_diff[CMP_W-1]) begin
			fmt_mask = '0;
		end else if (fmt_diff >= CMP_W'(WORD_BITS - 1)) begin
			fmt_mask = ONES;
		end else begin
			fmt_mask = ONES >> (BIT_W'(WORD_BITS - 1) - fmt_diff[BIT_W-1:0]);
		end
	end

	assign sweep_last = (sw_ptr_q == LAST_WORD);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sw_ptr_q;
		wr_data = '0;
		if (ctl.sweep) begin
			wr_en   = 1'b1;
			wr_data = ctl.sweep_zero ? '0 : fmt_mask;
		end else if (ctl.look) begin
			wr_en   = (cmd_q == CMD_RELEASE) && release_ok;
			wr_addr = ev_addr_s1;
			wr_data = rdata_q & ~bit_sel;
		end else if (ctl.scan) begin
			wr_en   = found;
			wr_addr = ev_addr_s1;
			wr_data = rdata_q | free_sel;
		end
	end

	assign rd_en   = (ctl.read && (cmd_q == CMD_ALLOC || in_range_q))
		|| (ctl.scan && !rd_done_q);
	assign rd_addr = ctl.read ? q_addr : rd_ptr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= map_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= command;
			id_q  <= blk_num;
		end
		if (ctl.div) begin
			opnd_q       <= div_opnd;
			q_q          <= div_quo;
			in_range_q   <= id_in_range;
			res_block_q  <= (cmd_q == CMD_ALLOC) ? '0 : id_q;
			res_status_q <= (cmd_q == CMD_ALLOC) ? ST_FULL : ST_OK;
			res_used_q   <= 1'b0;
		end
		if (ctl.read) begin
			r_q         <= rem;
			ev_addr_s1  <= q_addr;
			ev_base_s1  <= BASE_W'(q_base);
			ev_first_s1 <= 1'b1;
			rd_ptr_q    <= q_addr + AW'(1);
			base_q      <= BASE_W'(q_base) + BASE_W'(WORD_BITS);
			rd_done_q   <= (q_addr == LAST_WORD);
		end
		if (ctl.look) begin
			res_used_q <= id_bit;
			if ((cmd_q == CMD_RELEASE || cmd_q == CMD_CHECK) && !release_ok) begin
				res_status_q <= ST_BAD;
			end
		end
		if (ctl.scan) begin
			if (found) begin
				res_block_q  <= alloc_blk;
				res_status_q <= ST_OK;
			end
			if (!rd_done_q) begin
				ev_addr_s1  <= rd_ptr_q;
				ev_base_s1  <= base_q;
				ev_first_s1 <= 1'b0;
				rd_ptr_q    <= rd_ptr_q + AW'(1);
				base_q      <= base_q + BASE_W'(WORD_BITS);
				rd_done_q   <= (rd_ptr_q == LAST_WORD);
			end
		end
		if (ctl.resp_load) begin
			out_block_q  <= res_block_q;
			out_status_q <= res_status_q;
			out_used_q   <= res_used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_ptr_q  <= '0;
			sw_base_q <= '0;
		end else if (ctl.sweep) begin
			if (sweep_last) begin
				sw_ptr_q  <= '0;
				sw_base_q <= '0;
			end else begin
				sw_ptr_q  <= sw_ptr_q + AW'(1);
				sw_base_q <= sw_base_q + BASE_W'(WORD_BITS);
			end
		end
	end

	assign stat.cmd        = cmd_q;
	assign stat.start_ok   = start_ok;
	assign stat.scan_found = found;
	assign stat.scan_full  = !found && ev_last;
	assign stat.sweep_last = sweep_last;

	assign result_block = out_block_q;
	assign status       = out_status_q;
	assign is_used      = out_used_q;

endmodule

/* rtl/bitmap_block_allocator.sv */
// Top level of the bitmap block allocator: register port, controller and datapath.
//
// The block keeps one used bit per block and serves one request at a time on
// the req channel (command, blk_num); each request yields exactly one
// response on the rsp channel (result_block, status, is_used). Both channels
// move a request or response on a clock edge where valid and ready are high.
// Release and check pass through the divide, read and look states before the
// response. Allocate reads one map word per cycle starting at the word that
// holds the search start and examines at most BLOCK_COUNT / WORD_BITS words
// (128 by default). Format reads the named block's word and then writes
// every map word once, marking blocks 0 to reserved_last as used.
// A new request is accepted in the cycle after the response is loaded into
// the output register, even while that response still waits for the
// receiver; if the receiver stalls, the next finished response waits inside
// the block until the output register frees up. After reset the map is
// cleared by a pass over all BLOCK_COUNT / WORD_BITS words, one per cycle,
// during which no request is accepted; the APB registers are usable at once.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_macros.svh"
module bitmap_block_allocator import bba_pkg::*; #(
	parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
	parameter int WORD_BITS   = DEF_WORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	bba_req_if.sink            req,
	bba_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [BID_W-1:0] first_alloc_q;
	logic [BID_W-1:0] reserved_last_q;
	logic             cfg_wr;
	dp_ctl_t          dp_ctl;
	dp_stat_t         dp_stat;

	// The APB port never inserts wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers; the user must write them only while no request is in flight, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_alloc_q   <= FIRST_ALLOC_RST;
			reserved_last_q <= RESERVED_LAST_RST;
		end else if (cfg_wr) begin
			unique case (paddr[REG_SEL_BIT])
				REG_FIRST_ALLOC:   first_alloc_q   <= pwdata[BID_W-1:0];
				REG_RESERVED_LAST: reserved_last_q <= pwdata[BID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_FIRST_ALLOC:   prdata = PDATA_W'(first_alloc_q);
			REG_RESERVED_LAST: prdata = PDATA_W'(reserved_last_q);
			default:           prdata = '0;
		endcase
	end

	// The controller sequences each request; the datapath owns the map memory.
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (dp_stat),
		.ctl       (dp_ctl)
	);

	bba_dp #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.WORD_BITS   (WORD_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (dp_ctl),
		.stat              (dp_stat),
		.command           (req.command),
		.blk_num           (req.blk_num),
		.first_alloc_block (first_alloc_q),
		.reserved_last     (reserved_last_q),
		.result_block      (rsp.result_block),
		.status            (rsp.status),
		.is_used           (rsp.is_used)
	);

	// A response is never loaded over one that the receiver has not taken.
	`BBA_ASSERT_SAME(a_no_overwrite, clk, arst_n, dp_ctl.resp_load, !rsp.valid || rsp.ready)
	// Once a request is taken the block is busy with it in the next cycle.
	`BBA_ASSERT_NEXT(a_busy_after_take, clk, arst_n, req.valid && req.ready, !req.ready)
	// A full map answers block zero and a clear used flag.
	`BBA_ASSERT_SAME(a_full_is_zero, clk, arst_n, rsp.valid && rsp.status == ST_FULL,
		rsp.result_block == '0 && !rsp.is_used)

endmodule

/* dv/tb.sv */
// Self-checking testbench of the bitmap block allocator with a bitmap predictor and APB set-up.
`timescale 1ns / 1ps
module tb;
	import bba_pkg::*;

	// The block runs with its default geometry: 4096 blocks in 32-bit map words.
	localparam int MAP_BITS      = DEF_BLOCK_COUNT;
	// Receiver hold-off long enough for the block to fill and stall its input.
	localparam int LONG_HOLD     = 300;
	// Cycles to watch for stray responses once every answer has come; this is
	// longer than a full allocate scan or a format sweep.
	localparam int TAIL_WAIT     = 200;
	localparam int PHASE_ITEMS   = 55;
	// Watchdog limit on the whole run, in nanoseconds.
	localparam int TIME_LIMIT_NS = 1_000_000;

	// One response as the block should return it.
	typedef struct packed {
		logic [BID_W-1:0] block;
		logic [ST_W-1:0]  status;
		logic             used;
	} alloc_answer_t;

	// Keeps a private copy of the used map and both registers, works out the
	// answer to each accepted request and compares responses in order.
	class alloc_scoreboard;
		bit [MAP_BITS-1:0] used_bits;
		logic [BID_W-1:0]  first_alloc;
		logic [BID_W-1:0]  reserved_last;
		alloc_answer_t     answers_due[$];
		int                errors;

		function new();
			used_bits     = '0;
			first_alloc   = FIRST_ALLOC_RST;
			reserved_last = RESERVED_LAST_RST;
			errors        = 0;
		endfunction

		function void write_register(logic idx, logic [BID_W-1:0] value);
			if (idx == REG_FIRST_ALLOC) begin
				first_alloc = value;
			end else begin
				reserved_last = value;
			end
		endfunction

		function int pending();
			return answers_due.size();
		endfunction

		task report(string what);
			$display("MISMATCH at %0t ns: %s", $time, what);
			errors++;
		endtask

		// Applies one accepted request to the map and queues its answer.
		function void note_request(logic [CMD_W-1:0] cmd, logic [BID_W-1:0] id);
			alloc_answer_t ans;
			int            blk;
			int            start;
			bit            was_used;
			was_used   = used_bits[id];
			ans.block  = id;
			ans.status = ST_OK;
			ans.used   = was_used;
			case (cmd)
				CMD_ALLOC: begin
					// Block zero is never handed out: a zero start searches from one.
					start      = (first_alloc == '0) ? 1 : int'(first_alloc);
					ans.block  = '0;
					ans.status = ST_FULL;
					ans.used   = 1'b0;
					for (blk = start; blk < MAP_BITS; blk++) begin
						if (!used_bits[blk]) begin
							used_bits[blk] = 1'b1;
							ans.block      = BID_W'(blk);
							ans.status     = ST_OK;
							break;
						end
					end
				end
				CMD_RELEASE, CMD_CHECK: begin
					if (id == '0 || !was_used) begin
						ans.status = ST_BAD;
					end else if (cmd == CMD_RELEASE) begin
						used_bits[id] = 1'b0;
					end
				end
				CMD_FORMAT: begin
					used_bits = '0;
					for (blk = 0; blk <= int'(reserved_last); blk++) begin
						used_bits[blk] = 1'b1;
					end
				end
			endcase
			answers_due.push_back(ans);
		endfunction

		task check_response(logic [BID_W-1:0] blk, logic [ST_W-1:0] st, logic used);
			alloc_answer_t want;
			if (answers_due.size() == 0) begin
				report($sformatf("response block %0d status %0d with no request waiting",
					blk, st));
			end else begin
				want = answers_due.pop_front();
				if (blk !== want.block) begin
					report($sformatf("result_block %0d, expected %0d", blk, want.block));
				end
				if (st !== want.status) begin
					report($sformatf("status %0d, expected %0d (block %0d)",
						st, want.status, want.block));
				end
				if (used !== want.used) begin
					report($sformatf("is_used %0b, expected %0b (block %0d)",
						used, want.used, want.block));
				end
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// Idling is switched off for the final phase; the long receiver hold-off
	// is asked for by the stimulus and timed by the receiver itself.
	bit calm         = 1'b0;
	bit hold_request = 1'b0;

	alloc_scoreboard sb = new();

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();

	bitmap_block_allocator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch.sink),
		.rsp     (rsp_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Both channels are sampled at the rising edge, before any of this edge's
	// updates land, so a request accepted here is noted before the block can
	// possibly answer it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				sb.note_request(req_ch.command, req_ch.blk_num);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_response(rsp_ch.result_block, rsp_ch.status, rsp_ch.is_used);
			end
		end
	end

	// Receiver: random stalls between ready stretches, one long hold-off on
	// request, and ready held high once the run goes calm.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			if (hold_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	// Offers one request and returns at the edge where it is accepted. Valid
	// stays high so that back-to-back requests follow with no gap; a random
	// gap drops it and puts junk on the payload meanwhile.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BID_W-1:0] id);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid    <= 1'b0;
			req_ch.command  <= CMD_W'($urandom());
			req_ch.blk_num  <= BID_W'($urandom());
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.command  <= cmd;
		req_ch.blk_num  <= id;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stops offering and waits until every queued answer has come back. The
	// first edge lets the last acceptance be noted before the count is read.
	task automatic drain_answers();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// APB write of one register followed by a read-back. The upper data bits
	// carry junk, since only the low twelve bits belong to the register.
	task automatic cfg_write(input logic idx, input logic [BID_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word            = $urandom();
		word[BID_W-1:0] = value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(int'(idx) << REG_SEL_BIT);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[BID_W-1:0] !== value) begin
			sb.report($sformatf("register %0d reads %0d, written %0d",
				idx, prdata[BID_W-1:0], value));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic [BID_W-1:0] first, input logic [BID_W-1:0] top);
		cfg_write(REG_FIRST_ALLOC, first);
		cfg_write(REG_RESERVED_LAST, top);
	endtask

	// Ids for release and check lean towards blocks that are likely to be in
	// use: just above the allocation start and just below the reserved limit.
	function automatic logic [BID_W-1:0] pick_id();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return BID_W'($urandom());
			4:       return sb.reserved_last - BID_W'($urandom_range(0, 8));
			default: return sb.first_alloc + BID_W'($urandom_range(0, 40));
		endcase
	endfunction

	// Random mix of commands. The allocate share sets how fast the map fills;
	// hold_at and pause_at (negative for none) place the two pressure events.
	task automatic run_random_phase(input int items, input int alloc_pct,
		input int hold_at, input int pause_at);
		int n;
		int pick;
		for (n = 0; n < items; n++) begin
			if (n == hold_at) begin
				hold_request = 1'b1;
			end
			if (n == pause_at) begin
				drain_answers();
			end
			pick = $urandom_range(0, 99);
			if (pick < alloc_pct) begin
				send_request(CMD_ALLOC, BID_W'($urandom()));
			end else if (pick < alloc_pct + (95 - alloc_pct) / 2) begin
				send_request(CMD_RELEASE, pick_id());
			end else if (pick < 95) begin
				send_request(CMD_CHECK, pick_id());
			end else begin
				send_request(CMD_FORMAT, BID_W'($urandom()));
			end
		end
		drain_answers();
	endtask

	// Directed opening, in three groups under different register settings.
	task automatic run_directed();
		// Reset settings on an empty map: zero and top ids, double release,
		// lowest-free reuse, and a format that reserves blocks 0 to 513.
		send_request(CMD_CHECK, '0);
		send_request(CMD_CHECK, '1);
		send_request(CMD_RELEASE, '1);
		send_request(CMD_RELEASE, '0);
		send_request(CMD_ALLOC, '1);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_CHECK, 12'd514);
		send_request(CMD_RELEASE, 12'd514);
		send_request(CMD_RELEASE, 12'd514);
		send_request(CMD_ALLOC, 12'd7);
		send_request(CMD_FORMAT, '1);
		send_request(CMD_CHECK, '0);
		send_request(CMD_CHECK, 12'd513);
		send_request(CMD_RELEASE, 12'd513);
		send_request(CMD_ALLOC, 12'd513);
		drain_answers();
		// Zero start with a full format: the map is full, and the one block
		// freed must come back even though the start points at block zero.
		configure(12'd0, 12'd4095);
		send_request(CMD_FORMAT, '0);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_RELEASE, 12'd1);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_RELEASE, '0);
		send_request(CMD_ALLOC, '1);
		drain_answers();
		// Start at the very last block with only block zero reserved.
		configure(12'd4095, 12'd0);
		send_request(CMD_FORMAT, 12'd2048);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_CHECK, '1);
		drain_answers();
	endtask

	initial begin
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.command  <= CMD_ALLOC;
		req_ch.blk_num  <= '0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its map after reset; the first request simply
		// waits for ready.
		run_directed();

		configure(12'd0, 12'd0);
		run_random_phase(PHASE_ITEMS, 45, 8, -1);
		configure(12'd4095, 12'd4095);
		run_random_phase(PHASE_ITEMS, 40, -1, 20);
		// A start near the top with heavy allocation runs the map out.
		configure(12'd4064, 12'd100);
		run_random_phase(PHASE_ITEMS, 70, -1, -1);
		configure(12'd1, 12'd4095);
		run_random_phase(PHASE_ITEMS, 40, -1, -1);
		configure(BID_W'($urandom()), BID_W'($urandom()));
		run_random_phase(PHASE_ITEMS, 50, 30, -1);
		configure(BID_W'($urandom_range(3968, 4095)), BID_W'($urandom()));
		run_random_phase(PHASE_ITEMS, 60, -1, -1);

		// Final phase with no idling on either side.
		calm = 1'b1;
		configure(FIRST_ALLOC_RST, BID_W'($urandom()));
		run_random_phase(PHASE_ITEMS, 45, -1, -1);

		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#(TIME_LIMIT_NS);
		$display("TIMEOUT: %0d answers still due", sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_req_if.sv
rtl/bba_rsp_if.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/bitmap_block_allocator.sv
dv/tb.sv
